/* rtl/core/dsrr_pkg.sv */
// ----------------------------------------------------------------------------
// dsrr_pkg
// Shared constants and types for the dehaze radiance recovery block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsrr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PIX_W     = 8;
    localparam int TRANS_W   = 17;
    localparam int CH        = 3;
    localparam int NUM_W     = PIX_W + FRAC_BITS;   // |p - A| * 2^FRAC_BITS
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ATMOS_BLUE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATMOS_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATMOS_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRANS   = 3'd4;

    // one slot of the divider chain
    typedef struct packed {
        logic                               valid;
        logic [TRANS_W-1:0]                 trans;
        logic [CH-1:0][PIX_W-1:0]           pix;
        logic [CH-1:0]                      neg;
        logic [CH-1:0][NUM_W-1:0]           work;   // dividend out, quotient in
        logic [CH-1:0][TRANS_W-1:0]         rem;
    } slot_t;

endpackage

`default_nettype wire

/* rtl/core/dsrr_if.sv */
// ----------------------------------------------------------------------------
// dsrr_if
// Valid/ready channels for pixel items and recovered result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsrr_pix_if;
    logic                          valid;
    logic                          ready;
    logic [dsrr_pkg::PIX_W-1:0]    pixel_blue;
    logic [dsrr_pkg::PIX_W-1:0]    pixel_green;
    logic [dsrr_pkg::PIX_W-1:0]    pixel_red;
    logic [dsrr_pkg::TRANS_W-1:0]  trans_level;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, trans_level,
                    input ready);
    modport sink (input valid, pixel_blue, pixel_green, pixel_red, trans_level,
                  output ready);
endinterface

interface dsrr_res_if;
    logic                          valid;
    logic                          ready;
    logic [dsrr_pkg::PIX_W-1:0]    out_blue;
    logic [dsrr_pkg::PIX_W-1:0]    out_green;
    logic [dsrr_pkg::PIX_W-1:0]    out_red;

    modport source (output valid, out_blue, out_green, out_red, input ready);
    modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

`default_nettype wire

/* rtl/core/dsrr_div_cell.sv */
// ----------------------------------------------------------------------------
// dsrr_div_cell
// One restoring-division step for all three channels, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrr_div_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire dsrr_pkg::slot_t d_in,
    output dsrr_pkg::slot_t     q_out
);

    dsrr_pkg::slot_t slot_reg;
    dsrr_pkg::slot_t slot_next;

    always_comb
    begin
        logic [dsrr_pkg::TRANS_W:0] trial;
        logic                       ge;
        slot_next = d_in;
        for (int c = 0; c < dsrr_pkg::CH; c++)
        begin
            trial = {d_in.rem[c], d_in.work[c][dsrr_pkg::NUM_W-1]};
            ge    = trial >= {1'b0, d_in.trans};
            slot_next.rem[c]  = ge ? dsrr_pkg::TRANS_W'(trial - {1'b0, d_in.trans})
                                   : dsrr_pkg::TRANS_W'(trial);
            slot_next.work[c] = {d_in.work[c][dsrr_pkg::NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (en)
        begin
            slot_reg <= slot_next;
        end
    end

    assign q_out = slot_reg;

endmodule

`default_nettype wire

/* rtl/core/dehaze_scene_radiance_recovery.sv */
// ----------------------------------------------------------------------------
// dehaze_scene_radiance_recovery
// Per-pixel radiance q = (p - A)/t + A; negative -> 0, above ceiling -> p.
// ----------------------------------------------------------------------------
// One pixel item is accepted per clock and one result item leaves per clock
// unless the output is stalled. The pipe is one entry stage, a row of 24
// division cells (one quotient bit per cell, all three channels side by
// side) and one output register. The whole chain advances together; it
// stalls only while a finished result sits unclaimed in the output register.
// The config registers must be written only when the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dehaze_scene_radiance_recovery (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dsrr_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [dsrr_pkg::CFG_W-1:0]     cfg_data,
    dsrr_pix_if.sink                            pix,
    dsrr_res_if.source                          res
);

    localparam int NW = dsrr_pkg::NUM_W;
    localparam int PW = dsrr_pkg::PIX_W;
    localparam int TW = dsrr_pkg::TRANS_W;

    // ---------------- config registers ----------------
    logic [dsrr_pkg::CH-1:0][PW-1:0] atmos_reg;
    logic [PW-1:0]                   ceil_reg;
    logic [TW-1:0]                   tmin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atmos_reg <= {dsrr_pkg::CH{8'd255}};
            ceil_reg  <= 8'd240;
            tmin_reg  <= 17'd6554;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                dsrr_pkg::CFG_ATMOS_BLUE:  atmos_reg[0] <= cfg_data[PW-1:0];
                dsrr_pkg::CFG_ATMOS_GREEN: atmos_reg[1] <= cfg_data[PW-1:0];
                dsrr_pkg::CFG_ATMOS_RED:   atmos_reg[2] <= cfg_data[PW-1:0];
                dsrr_pkg::CFG_CEILING:     ceil_reg     <= cfg_data[PW-1:0];
                dsrr_pkg::CFG_MIN_TRANS:   tmin_reg     <= cfg_data[TW-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Global advance: everything moves unless the output item is stalled.
    logic en;
    logic out_valid_reg;
    assign en        = !out_valid_reg || res.ready;
    assign pix.ready = en;

    // ---------------- entry stage ----------------
    // Floor the transmission, split |p - A| and its sign, and scale by 2^FRAC.
    dsrr_pkg::slot_t entry_next;
    dsrr_pkg::slot_t entry_reg;

    always_comb
    begin
        logic [TW-1:0]           t_fl;
        logic [PW:0]             diff;
        logic [dsrr_pkg::CH-1:0][PW-1:0] p;
        p[0] = pix.pixel_blue;
        p[1] = pix.pixel_green;
        p[2] = pix.pixel_red;
        t_fl = (pix.trans_level < tmin_reg) ? tmin_reg : pix.trans_level;
        if (t_fl == '0)
        begin
            t_fl = TW'(1);  // zero transmission divides by one
        end
        entry_next       = '0;
        entry_next.valid = pix.valid;
        entry_next.trans = t_fl;
        entry_next.pix   = p;
        for (int c = 0; c < dsrr_pkg::CH; c++)
        begin
            diff = {1'b0, p[c]} - {1'b0, atmos_reg[c]};
            entry_next.neg[c]  = diff[PW];
            entry_next.work[c] = {(diff[PW] ? PW'(-diff) : diff[PW-1:0]),
                                  {dsrr_pkg::FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (en)
        begin
            entry_reg <= entry_next;
        end
    end

    // ---------------- division chain ----------------
    // Cell k produces quotient bit NW-1-k; after the last cell work holds
    // floor(|d|*S/t) and rem the remainder.
    dsrr_pkg::slot_t chain [NW+1];
    assign chain[0] = entry_reg;

    for (genvar k = 0; k < NW; k++)
    begin : g_cell
        dsrr_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (chain[k]),
            .q_out (chain[k+1])
        );
    end

    // ---------------- finish and output register ----------------
    // Positive d: q = A + floor(|d|S/t). Negative d: q = A - ceil(|d|S/t),
    // which equals the truncated quotient whenever it is not negative.
    dsrr_pkg::slot_t                 last;
    logic [dsrr_pkg::CH-1:0][PW-1:0] res_next;
    logic [dsrr_pkg::CH-1:0][PW-1:0] res_reg;

    assign last = chain[NW];

    always_comb
    begin
        logic [NW+1:0] mag;
        logic [NW+1:0] a_ext;
        logic [NW+1:0] q;
        for (int c = 0; c < dsrr_pkg::CH; c++)
        begin
            mag   = (NW+2)'(last.work[c])
                  + (NW+2)'(last.neg[c] && (last.rem[c] != '0));
            a_ext = (NW+2)'(atmos_reg[c]);
            q     = last.neg[c] ? a_ext - mag : a_ext + mag;
            if (q[NW+1])
            begin
                res_next[c] = '0;                   // negative result
            end
            else if (q > (NW+2)'(ceil_reg))
            begin
                res_next[c] = last.pix[c];          // above ceiling: keep input
            end
            else
            begin
                res_next[c] = q[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_blue  = res_reg[0];
    assign res.out_green = res_reg[1];
    assign res.out_red   = res_reg[2];

endmodule

`default_nettype wire

/* rtl/core/dsrr_checker.sv */
// ----------------------------------------------------------------------------
// dsrr_checker
// Port-level checks on the radiance recovery block's handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [dsrr_pkg::PIX_W-1:0] out_blue,
    input wire logic [dsrr_pkg::PIX_W-1:0] out_green,
    input wire logic [dsrr_pkg::PIX_W-1:0] out_red
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output is empty");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output is stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_blue)
                                       && $stable(out_green) && $stable(out_red)))
        else $error("stalled result changed");

endmodule

bind dehaze_scene_radiance_recovery dsrr_checker u_dsrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_blue  (res.out_blue),
    .out_green (res.out_green),
    .out_red   (res.out_red)
);

`default_nettype wire

/* verif/tb_dehaze_scene_radiance_recovery.sv */
// ----------------------------------------------------------------------------
// tb_dehaze_scene_radiance_recovery
// Checks the recovered pixel values against a behavioral model of the
// radiance recovery.
// Pixel items are sent in random bursts and the result side stalls at random.
// Config is rewritten only while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dehaze_scene_radiance_recovery;

    localparam int LATENCY    = dsrr_pkg::NUM_W + 2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [dsrr_pkg::PIX_W-1:0]   b;
        logic [dsrr_pkg::PIX_W-1:0]   g;
        logic [dsrr_pkg::PIX_W-1:0]   r;
        logic [dsrr_pkg::TRANS_W-1:0] t;
    } pixel_t;

    typedef struct packed {
        logic [dsrr_pkg::PIX_W-1:0] b;
        logic [dsrr_pkg::PIX_W-1:0] g;
        logic [dsrr_pkg::PIX_W-1:0] r;
    } radiance_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic [dsrr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [dsrr_pkg::CFG_W-1:0] cfg_data = '0;

    dsrr_pix_if pix ();
    dsrr_res_if res ();

    dehaze_scene_radiance_recovery dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .pix      (pix.sink),
        .res      (res.source)
    );

    always #2 clk = ~clk;

    // predictor's own copy of the registers
    logic [7:0]  atm_b = 8'd255, atm_g = 8'd255, atm_r = 8'd255;
    logic [7:0]  ceil_lvl = 8'd240;
    logic [16:0] t_floor = 17'd6554;

    pixel_t    pending_pixels[$];
    radiance_t expected_radiance[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        feeding = 1'b0;

    function automatic logic [7:0] recover(logic [7:0] p, logic [7:0] a,
                                           logic [16:0] t, logic [7:0] c);
        longint num;
        longint q;
        num = (longint'(p) - longint'(a)) * (longint'(1) << dsrr_pkg::FRAC_BITS)
              + longint'(a) * longint'(t);
        q = num / longint'(t);   // SV division truncates toward zero
        if (q > longint'(c))
            q = p;
        if (q < 0)
            q = 0;
        return q[7:0];
    endfunction

    function automatic radiance_t predict_radiance(pixel_t px);
        radiance_t o;
        logic [16:0] t;
        t = px.t;
        if (t < t_floor)
            t = t_floor;
        if (t == 0)
            t = 1;
        o.b = recover(px.b, atm_b, t, ceil_lvl);
        o.g = recover(px.g, atm_g, t, ceil_lvl);
        o.r = recover(px.r, atm_r, t, ceil_lvl);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // append helpers for the two queues
    function automatic void queue_pixel(pixel_t px);
        pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    function automatic void queue_expected(radiance_t rd);
        expected_radiance.insert(expected_radiance.size(), rd);
    endfunction

    // ---------------- driver ----------------
    // bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            queue_expected(predict_radiance(pending_pixels.pop_front()));
        end
        if (!rst_n || !feeding)
        begin
            pix.valid <= 1'b0;
        end
        else if (!(pix.valid && !pix.ready))
        begin
            // either holding nothing or the last item just went in
            if (gap_left > 0)
            begin
                gap_left--;
                pix.valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                pix.valid       <= 1'b1;
                pix.pixel_blue  <= pending_pixels[0].b;
                pix.pixel_green <= pending_pixels[0].g;
                pix.pixel_red   <= pending_pixels[0].r;
                pix.trans_level <= pending_pixels[0].t;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            else
                pix.valid <= 1'b0;
        end
    end

    // the driver peeks at the head of the queue, so it pops on acceptance only
    initial
    begin
        pix.valid = 1'b0;
        pix.pixel_blue = '0;
        pix.pixel_green = '0;
        pix.pixel_red = '0;
        pix.trans_level = '0;
        res.ready = 1'b0;
    end

    // ---------------- monitor ----------------
    // receiver stall pattern: periodic windows plus random drops
    int stall_phase = 0;
    always @(posedge clk)
    begin
        radiance_t want;
        if (res.valid && res.ready)
        begin
            if (expected_radiance.size() == 0)
            begin
                report_mismatch("unexpected item", 0, 0);
            end
            else
            begin
                want = expected_radiance.pop_front();
                if (res.out_blue !== want.b)
                    report_mismatch("blue", res.out_blue, want.b);
                if (res.out_green !== want.g)
                    report_mismatch("green", res.out_green, want.g);
                if (res.out_red !== want.r)
                    report_mismatch("red", res.out_red, want.r);
            end
        end
        if ((pix.valid && pix.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        stall_phase = (stall_phase + 1) % 97;
        if (!rst_n)
            res.ready <= 1'b0;
        else if (stall_phase < 40)
            res.ready <= 1'b1;        // stretch with no stalls
        else if (stall_phase < 50)
            res.ready <= 1'b0;        // long stall
        else
            res.ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequencer ----------------
    task automatic write_reg(logic [dsrr_pkg::CFG_IDX_W-1:0] idx,
                             logic [dsrr_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            dsrr_pkg::CFG_ATMOS_BLUE:  atm_b = val[7:0];
            dsrr_pkg::CFG_ATMOS_GREEN: atm_g = val[7:0];
            dsrr_pkg::CFG_ATMOS_RED:   atm_r = val[7:0];
            dsrr_pkg::CFG_CEILING:     ceil_lvl = val[7:0];
            dsrr_pkg::CFG_MIN_TRANS:   t_floor = val[16:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        feeding = 1'b1;
        wait (pending_pixels.size() == 0 && expected_radiance.size() == 0);
        feeding = 1'b0;
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [16:0] rand_trans();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'(1 << dsrr_pkg::FRAC_BITS)
                      + 17'($urandom_range(0, 65535)); // above one
            3: return 17'($urandom_range(0, 255));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.b = 8'($urandom);
        px.g = 8'($urandom);
        px.r = 8'($urandom);
        px.t = rand_trans();
        return px;
    endfunction

    task automatic add_pixel(int b, int g, int r, int t);
        pixel_t px;
        px.b = 8'(b); px.g = 8'(g); px.r = 8'(r); px.t = 17'(t);
        queue_pixel(px);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset config: extremes, zero transmission, above one
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(255, 255, 255, 65536);
        add_pixel(0, 128, 255, 65536);
        add_pixel(10, 200, 250, 6554);
        add_pixel(100, 50, 241, 6553);
        add_pixel(0, 0, 0, 131071);
        add_pixel(255, 0, 255, 1);
        drain();

        // low floor, zero ceiling, atmosphere 0/128/255: results above ceiling, negatives
        write_reg(dsrr_pkg::CFG_ATMOS_BLUE, 17'd0);
        write_reg(dsrr_pkg::CFG_ATMOS_GREEN, 17'd128);
        write_reg(dsrr_pkg::CFG_ATMOS_RED, 17'd255);
        write_reg(dsrr_pkg::CFG_CEILING, 17'd0);
        write_reg(dsrr_pkg::CFG_MIN_TRANS, 17'd1);
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 1);
        add_pixel(1, 127, 254, 65536);
        add_pixel(0, 128, 255, 100);
        add_pixel(255, 0, 0, 131071);
        drain();
        write_reg(dsrr_pkg::CFG_CEILING, 17'd255);
        write_reg(dsrr_pkg::CFG_MIN_TRANS, 17'd65536);
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 131071);
        add_pixel(17, 170, 200, 70000);
        drain();

        // random phases, each with a fresh random config (extremes included)
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(dsrr_pkg::CFG_ATMOS_BLUE,
                      (ph == 0) ? 17'd255 : 17'($urandom_range(0, 255)));
            write_reg(dsrr_pkg::CFG_ATMOS_GREEN,
                      (ph == 1) ? 17'd0 : 17'($urandom_range(0, 255)));
            write_reg(dsrr_pkg::CFG_ATMOS_RED, 17'($urandom_range(0, 255)));
            write_reg(dsrr_pkg::CFG_CEILING,
                      (ph < 2) ? 17'd255 : 17'($urandom_range(0, 255)));
            write_reg(dsrr_pkg::CFG_MIN_TRANS, (ph == 2) ? 17'd65536 :
                      (ph == 3) ? 17'd1 : 17'($urandom_range(1, 65536)));
            for (int i = 0; i < 175; i++)
                queue_pixel(rand_pixel());
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/dsrr_pkg.sv
rtl/core/dsrr_if.sv
rtl/core/dsrr_div_cell.sv
rtl/core/dehaze_scene_radiance_recovery.sv
rtl/core/dsrr_checker.sv
verif/tb_dehaze_scene_radiance_recovery.sv
